// File: rtl/core/lrupr_pkg.sv
// Shared constants for the LRU page frame replacement core.
`timescale 1ns / 1ps
package lrupr_pkg;

  // Built frame count and page number width.
  localparam int unsigned FRAMES_DEF    = 8;
  localparam int unsigned PAGE_BITS_DEF = 16;

  // Configuration register layout.
  localparam int unsigned CFG_W          = 4;
  localparam int unsigned ADDR_W         = 3;
  localparam logic        REG_FRAME_COUNT = 1'b0;
  localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 4'd8;

  // Fault counter width.
  localparam int unsigned FAULT_W = 32;

endpackage

// File: rtl/core/lru_page_frame_replacement_core.sv
// LRU page frame replacement core: page table scan, victim choice and fault count.
// The result word is registered in the update state, after the scan of the frames in use.
// One frame is read from the page RAM and compared per cycle, through one shared compare unit.
// The core takes no new word until the current one is through: in_stall stays high from acceptance to the update.
// Reset: all frames empty, frame i holds rank i, fault count zero, frame count eight.
`timescale 1ns / 1ps
module lru_page_frame_replacement_core
  import lrupr_pkg::*;
#(
  parameter int unsigned FRAMES    = FRAMES_DEF,
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF,
  localparam int unsigned FIW      = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // Page reference channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PAGE_BITS-1:0] page_number,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 hit,
  output logic [FIW-1:0]       frame_index,
  output logic                 evicted_valid,
  output logic [PAGE_BITS-1:0] evicted_page,
  output logic [FAULT_W-1:0]   fault_total
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  localparam logic [FIW-1:0] RANK_MAX = FIW'(FRAMES - 1);

  logic [1:0]           state;
  logic [CFG_W-1:0]     frame_count;
  logic [FIW-1:0]       last_idx;

  logic [PAGE_BITS-1:0] page;
  logic [FIW-1:0]       scan_idx;
  logic                 issue_done;
  logic                 cmp_vld;
  logic                 cmp_last;
  logic [FIW-1:0]       cmp_idx;

  logic                 hit_found;
  logic [FIW-1:0]       hit_idx;
  logic [FIW-1:0]       hit_rank;
  logic                 empty_found;
  logic [FIW-1:0]       empty_idx;
  logic [FIW-1:0]       empty_rank;
  logic [FIW-1:0]       lru_idx;
  logic [FIW-1:0]       lru_rank;
  logic [PAGE_BITS-1:0] lru_page;

  logic [FRAMES-1:0]    frame_valid;
  logic [FIW-1:0]       recency_rank [FRAMES];
  logic [FAULT_W-1:0]   faults_seen;
  logic [FAULT_W-1:0]   faults_seen_next;

  logic [PAGE_BITS-1:0] ram_rdata;
  logic                 ram_we;
  logic [FIW-1:0]       slot;
  logic [FIW-1:0]       slot_rank;
  logic                 cur_hit;
  logic                 cur_match;
  logic                 in_accept;
  logic                 update_go;
  logic                 cfg_write;

  // Configuration register, always ready.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & (paddr[2] == REG_FRAME_COUNT);
  assign prdata    = (paddr[2] == REG_FRAME_COUNT) ? {{(32 - CFG_W){1'b0}}, frame_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RESET;
    end else if (cfg_write) begin
      frame_count <= pwdata[CFG_W-1:0];
    end
  end

  // Highest frame index in use, with the count clamped to one and to the built size.
  always_comb begin
    if (frame_count == '0) begin
      last_idx = '0;
    end else if (32'(frame_count) > FRAMES) begin
      last_idx = RANK_MAX;
    end else begin
      last_idx = FIW'(frame_count - 1'b1);
    end
  end

  // Handshake terms.
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign update_go = (state == ST_UPDATE) & (~out_valid | ~out_stall);

  // Page RAM: read during the scan, written with the new page on a fault.
  assign cur_hit = hit_found;
  always_comb begin
    if (cur_hit) begin
      slot      = hit_idx;
      slot_rank = hit_rank;
    end else if (empty_found) begin
      slot      = empty_idx;
      slot_rank = empty_rank;
    end else begin
      slot      = lru_idx;
      slot_rank = lru_rank;
    end
  end
  assign ram_we = update_go & ~cur_hit;

  lrupr_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (FRAMES)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (page),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  // The shared compare unit looks at one frame per cycle.
  assign cur_match = frame_valid[cmp_idx] & (ram_rdata == page);

  // Sequencer: accept, scan the frames in use, then update state and present the word.
  // The last compare always follows the last issue, so the compare stage empties by itself.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cmp_vld    <= 1'b0;
      issue_done <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state      <= ST_SCAN;
            cmp_vld    <= 1'b0;
            issue_done <= 1'b0;
          end
        end
        ST_SCAN: begin
          cmp_vld <= ~issue_done;
          if (!issue_done && scan_idx == last_idx) begin
            issue_done <= 1'b1;
          end
          if (cmp_vld && cmp_last) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (update_go) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Scan address, compare stage and running search results.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      page        <= page_number;
      scan_idx    <= '0;
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
      lru_idx     <= '0;
      lru_rank    <= '1;
    end else if (state == ST_SCAN) begin
      if (!issue_done) begin
        cmp_idx  <= scan_idx;
        cmp_last <= (scan_idx == last_idx);
        if (scan_idx != last_idx) begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
      if (cmp_vld) begin
        // Lowest matching frame wins.
        if (cur_match && !hit_found) begin
          hit_found <= 1'b1;
          hit_idx   <= cmp_idx;
          hit_rank  <= recency_rank[cmp_idx];
        end
        // Lowest empty frame.
        if (!frame_valid[cmp_idx] && !empty_found) begin
          empty_found <= 1'b1;
          empty_idx   <= cmp_idx;
          empty_rank  <= recency_rank[cmp_idx];
        end
        // Least recent frame; ranks are unique, so the first seen keeps ties.
        if (recency_rank[cmp_idx] < lru_rank) begin
          lru_idx  <= cmp_idx;
          lru_rank <= recency_rank[cmp_idx];
          lru_page <= ram_rdata;
        end else if (cmp_idx == '0) begin
          lru_page <= ram_rdata;
        end
      end
    end
  end

  // Saturating fault count.
  assign faults_seen_next = (faults_seen == '1) ? faults_seen : faults_seen + 1'b1;

  // Frame state update: valid marks, ranks and fault total.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      faults_seen <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        recency_rank[i] <= FIW'(i);
      end
    end else if (update_go) begin
      if (!cur_hit) begin
        frame_valid[slot] <= 1'b1;
        faults_seen       <= faults_seen_next;
      end
      for (int i = 0; i < FRAMES; i++) begin
        if (FIW'(i) == slot) begin
          recency_rank[i] <= RANK_MAX;
        end else if (recency_rank[i] > slot_rank) begin
          recency_rank[i] <= recency_rank[i] - 1'b1;
        end
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (update_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (update_go) begin
      hit           <= cur_hit;
      frame_index   <= slot;
      evicted_valid <= ~cur_hit & ~empty_found;
      evicted_page  <= (~cur_hit & ~empty_found) ? lru_page : '0;
      fault_total   <= cur_hit ? faults_seen : faults_seen_next;
    end
  end

endmodule

// File: rtl/core/lrupr_ram.sv
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps
module lrupr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/lrupr_chk.sv
// Port-level checker for the LRU page frame replacement core, with its bind.
`timescale 1ns / 1ps
module lrupr_chk
  import lrupr_pkg::*;
#(
  parameter int unsigned FRAMES    = FRAMES_DEF,
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF,
  localparam int unsigned FIW      = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 hit,
  input logic [FIW-1:0]       frame_index,
  input logic                 evicted_valid,
  input logic [PAGE_BITS-1:0] evicted_page,
  input logic [FAULT_W-1:0]   fault_total
);

  // A stalled result word holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit) && $stable(frame_index)
      && $stable(evicted_valid) && $stable(evicted_page) && $stable(fault_total))
    else $error("stalled result word changed");

  // The core is busy for at least the cycle after it takes a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("core ready again straight after accepting a word");

  // A hit never evicts and reports a zero evicted page.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !evicted_valid && (evicted_page == '0))
    else $error("hit reported an eviction");

  // A fault always shows a non-zero fault total.
  a_fault_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> (fault_total != '0))
    else $error("fault reported with a zero fault total");

  // No result word comes straight out of reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word valid just after reset");

endmodule

bind lru_page_frame_replacement_core lrupr_chk #(
  .FRAMES    (FRAMES),
  .PAGE_BITS (PAGE_BITS)
) u_lrupr_chk (.*);
